FILE: sv/ping_challenge_table_top_macros.svh
// Assertion macros used by the ping challenge table top level.
`ifndef PING_CHALLENGE_TABLE_TOP_MACROS_SVH
`define PING_CHALLENGE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pct_pkg.sv
// Package with the types, codes and the packing helper of the ping challenge table.
`timescale 1ns / 1ps
package pct_pkg;

	// Default table size and the cap on fired entries for one pong.
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int MAX_FIRE        = 64;
	localparam int FIRE_CNT_W      = $clog2(MAX_FIRE + 1);

	// Port widths.
	localparam int IN_TDATA_W  = 224;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_TUSER_W = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;

	// Request kinds.
	localparam logic [1:0] REQ_ISSUE = 2'd0;
	localparam logic [1:0] REQ_PONG  = 2'd1;
	localparam logic [1:0] REQ_PING  = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_BAD     = 3'd2;
	localparam logic [2:0] ST_NOMATCH = 3'd3;
	localparam logic [2:0] ST_NOTUS   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_MY_IDENTITY     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LENGTH = 2'd1;

	// One table entry as it sits in the memory.
	typedef struct packed {
		logic        valid;
		logic [63:0] peer;
		logic [31:0] challenge;
		logic [31:0] sent_time;
		logic [15:0] action;
	} entry_t;

	// Result tdata: slot, fired_action, challenge_out, send_pong, one pad bit.
	function automatic logic [OUT_TDATA_W-1:0] pack_result(
		input logic [5:0]  slot,
		input logic [15:0] action,
		input logic [31:0] chal,
		input logic        pong
	);
		pack_result = {1'b0, pong, chal, action, slot};
	endfunction

endpackage

FILE: sv/ping_challenge_table_top.sv
// Top level of the ping challenge table: control, scan sequencer and result register.
`timescale 1ns / 1ps
`include "ping_challenge_table_top_macros.svh"
// Table of outstanding ping challenges.
//
// Requests arrive as beats on the s_axis channel (kind in tuser, fields in tdata).
// An issue request scans the whole table for the entry with the oldest send time
// before now and writes the new challenge there. A received pong is checked, then
// the table is scanned and every matching entry is fired and cleared, one result
// beat each, tlast on the final one. A received ping is answered straight away.
// Results leave on the m_axis channel from an output register, so a new request
// can be taken while the last result still waits for the receiver.
//
// Timing: the scan reads one entry per cycle from the table memory, whose read
// port sets the pace, unless a stall holds it. An issue or a pong scans the whole
// table before its final result; a received ping or a rejected message goes
// straight to its result. One request is handled at a time; s_axis_tready is
// high only while the block is idle. A stalled receiver holds the scan only when
// a second match needs the output register; everything else simply waits in place.
//
// After reset a sweep clears all TABLE_DEPTH entries, one entry a cycle, during
// which no request is taken. Configuration writes are always taken.
module ping_challenge_table_top #(
	parameter int TABLE_DEPTH = pct_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request channel.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata from bit 0 up: peer_id, msg_receiver, msg_length, challenge,
	// now_seconds, action_handle.
	input  logic [pct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: req_type.
	input  logic [pct_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	// Result channel.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata from bit 0 up: slot, fired_action, challenge_out, send_pong, pad.
	output logic [pct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// tuser: status.
	output logic [pct_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	output logic                            m_axis_tlast,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pct_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pct_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pct_pkg::*;

	localparam int IdxW = $clog2(TABLE_DEPTH);
	localparam int CntW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_CLR  = 4'b0001,
		S_IDLE = 4'b0010,
		S_SCAN = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [63:0] my_identity_q;
	logic [15:0] expected_length_q;

	// Request fields unpacked from the input beat.
	logic [1:0]  in_req;
	logic [63:0] in_peer;
	logic [63:0] in_rcv;
	logic [15:0] in_len;
	logic [31:0] in_chal;
	logic [31:0] in_now;
	logic [15:0] in_act;

	assign in_req  = s_axis_tuser[1:0];
	assign in_peer = s_axis_tdata[63:0];
	assign in_rcv  = s_axis_tdata[127:64];
	assign in_len  = s_axis_tdata[143:128];
	assign in_chal = s_axis_tdata[175:144];
	assign in_now  = s_axis_tdata[207:176];
	assign in_act  = s_axis_tdata[223:208];

	// Latched request.
	logic [63:0] peer_q;
	logic [31:0] chal_q;
	logic [31:0] now_q;
	logic [15:0] act_q;
	logic        is_issue_q;

	// Scan state.
	logic [IdxW-1:0]       clr_idx_q;
	logic [CntW-1:0]       rd_cnt_q;
	logic                  s1_valid_q;
	logic [IdxW-1:0]       s1_idx_q;
	entry_t                rd_data_s1;
	logic [31:0]           best_q;
	logic [IdxW-1:0]       pick_q;
	logic                  found_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;

	// A fired entry waits here until it is known whether another one follows.
	logic            pend_valid_q;
	logic [IdxW-1:0] pend_slot_q;
	logic [15:0]     pend_action_q;

	// Final result of the request, sent from S_RESP.
	logic [2:0]  res_status_q;
	logic [5:0]  res_slot_q;
	logic [15:0] res_action_q;
	logic [31:0] res_chal_q;
	logic        res_pong_q;

	// Output register.
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;
	logic [OUT_TUSER_W-1:0] out_tuser_q;
	logic                   out_tlast_q;

	// Memory ports.
	logic            wr_en;
	logic [IdxW-1:0] wr_addr;
	entry_t          wr_data;
	logic            rd_en;
	logic [IdxW-1:0] rd_idx;

	logic accept_in;
	logic out_free;
	logic rd_left;
	logic match;
	logic stall;
	logic scan_done;
	logic push_scan;
	logic push_resp;

	// Decode of a request in the idle state.
	logic       dec_scan;
	logic [2:0] dec_status;
	logic [31:0] dec_chal;
	logic       dec_pong;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept_in     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign rd_idx    = rd_cnt_q[IdxW-1:0];
	assign rd_left   = (rd_cnt_q != CntW'(TABLE_DEPTH));
	assign match     = s1_valid_q && !is_issue_q && rd_data_s1.valid
		&& (rd_data_s1.challenge == chal_q) && (rd_data_s1.peer == peer_q)
		&& (fire_cnt_q != FIRE_CNT_W'(MAX_FIRE));
	// A second match has to push the held one out; that needs a free output.
	assign stall     = match && pend_valid_q && !out_free;
	assign rd_en     = (state_q == S_SCAN) && rd_left && !stall;
	assign scan_done = (state_q == S_SCAN) && !rd_left && !s1_valid_q;
	assign push_scan = match && pend_valid_q && out_free;
	assign push_resp = (state_q == S_RESP) && out_free;

	always_comb begin
		dec_scan   = 1'b0;
		dec_status = ST_OK;
		dec_chal   = '0;
		dec_pong   = 1'b0;
		unique case (in_req)
			REQ_ISSUE: begin
				dec_scan = 1'b1;
			end
			REQ_PONG: begin
				if ((in_len != expected_length_q) || (in_peer != in_rcv)) begin
					dec_status = ST_BAD;
				end else begin
					dec_scan = 1'b1;
				end
			end
			REQ_PING: begin
				if (in_len != expected_length_q) begin
					dec_status = ST_BAD;
				end else if (in_rcv != my_identity_q) begin
					dec_status = ST_NOTUS;
				end else begin
					dec_chal = in_chal;
					dec_pong = 1'b1;
				end
			end
			default: begin
				dec_status = ST_BAD;
			end
		endcase
	end

	// One write port: clearing sweep, clearing a fired entry, or storing an issue.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_idx_q;
		wr_data = '0;
		if (state_q == S_CLR) begin
			wr_en = 1'b1;
		end else if (match && !stall) begin
			wr_en   = 1'b1;
			wr_addr = s1_idx_q;
		end else if (scan_done && is_issue_q && found_q) begin
			wr_en             = 1'b1;
			wr_addr           = pick_q;
			wr_data.valid     = 1'b1;
			wr_data.peer      = peer_q;
			wr_data.challenge = chal_q;
			wr_data.sent_time = now_q;
			wr_data.action    = act_q;
		end
	end

	pct_ram #(
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_idx),
		.rd_data(rd_data_s1)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_CLR;
			clr_idx_q         <= '0;
			rd_cnt_q          <= '0;
			s1_valid_q        <= 1'b0;
			found_q           <= 1'b0;
			fire_cnt_q        <= '0;
			pend_valid_q      <= 1'b0;
			out_valid_q       <= 1'b0;
			my_identity_q     <= '0;
			expected_length_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MY_IDENTITY:     my_identity_q     <= cfg_data;
					CFG_EXPECTED_LENGTH: expected_length_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (push_scan || push_resp) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IdxW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept_in) begin
						rd_cnt_q   <= '0;
						found_q    <= 1'b0;
						fire_cnt_q <= '0;
						state_q    <= dec_scan ? S_SCAN : S_RESP;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_cnt_q   <= rd_cnt_q + 1'b1;
						s1_valid_q <= 1'b1;
					end else if (!stall) begin
						s1_valid_q <= 1'b0;
					end
					if (s1_valid_q && is_issue_q && (best_q > rd_data_s1.sent_time)) begin
						found_q <= 1'b1;
					end
					if (match && !stall) begin
						pend_valid_q <= 1'b1;
						fire_cnt_q   <= fire_cnt_q + 1'b1;
					end
					if (scan_done) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			peer_q       <= in_peer;
			chal_q       <= in_chal;
			now_q        <= in_now;
			act_q        <= in_act;
			best_q       <= in_now;
			is_issue_q   <= (in_req == REQ_ISSUE);
			res_status_q <= dec_status;
			res_slot_q   <= '0;
			res_action_q <= '0;
			res_chal_q   <= dec_chal;
			res_pong_q   <= dec_pong;
		end

		if (rd_en) begin
			s1_idx_q <= rd_idx;
		end

		// Oldest send time strictly before now; the first one wins a tie.
		if (s1_valid_q && is_issue_q && (best_q > rd_data_s1.sent_time)) begin
			best_q <= rd_data_s1.sent_time;
			pick_q <= s1_idx_q;
		end

		if (match && !stall) begin
			pend_slot_q   <= s1_idx_q;
			pend_action_q <= rd_data_s1.action;
		end

		if (scan_done) begin
			res_pong_q <= 1'b0;
			if (is_issue_q) begin
				res_action_q <= '0;
				if (found_q) begin
					res_status_q <= ST_OK;
					res_slot_q   <= 6'(pick_q);
					res_chal_q   <= chal_q;
				end else begin
					res_status_q <= ST_FULL;
					res_slot_q   <= '0;
					res_chal_q   <= '0;
				end
			end else begin
				res_chal_q <= '0;
				if (pend_valid_q) begin
					res_status_q <= ST_OK;
					res_slot_q   <= 6'(pend_slot_q);
					res_action_q <= pend_action_q;
				end else begin
					res_status_q <= ST_NOMATCH;
					res_slot_q   <= '0;
					res_action_q <= '0;
				end
			end
		end

		if (push_scan) begin
			out_tdata_q <= pack_result(6'(pend_slot_q), pend_action_q, 32'd0, 1'b0);
			out_tuser_q <= ST_OK;
			out_tlast_q <= 1'b0;
		end else if (push_resp) begin
			out_tdata_q <= pack_result(res_slot_q, res_action_q, res_chal_q, res_pong_q);
			out_tuser_q <= res_status_q;
			out_tlast_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_tuser_q;
	assign m_axis_tlast  = out_tlast_q;

	// The entry being cleared is never the one being read in the same cycle.
	`PCT_ASSERT_NOW(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_idx,
		"table write and read hit the same entry")
	// No more than the cap of entries fire for one pong.
	`PCT_ASSERT_NOW(a_fire_cap, 1'b1, fire_cnt_q <= FIRE_CNT_W'(MAX_FIRE),
		"fire count beyond cap")
	// The read pointer never runs past the end of the table.
	`PCT_ASSERT_NOW(a_rd_bound, 1'b1, rd_cnt_q <= CntW'(TABLE_DEPTH),
		"scan read pointer past table end")
	// Nothing from a scan is left over once the block is idle again.
	`PCT_ASSERT_NOW(a_idle_clean, state_q == S_IDLE, !pend_valid_q && !s1_valid_q,
		"scan state left over in idle")
	// A finished scan always hands over to the final result.
	`PCT_ASSERT_NEXT(a_done_resp, scan_done, state_q == S_RESP,
		"scan end did not move to the response")

endmodule

FILE: sv/pct_ram.sv
// Single-port-write, single-port-read table memory with a registered read.
`timescale 1ns / 1ps
module pct_ram #(
	parameter int DEPTH = pct_pkg::TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  pct_pkg::entry_t          wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output pct_pkg::entry_t          rd_data
);
	import pct_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data stays put while the read enable is low.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
